// ===== rtl/ipv4_udp_receive_filter_macros.svh =====
`ifndef IPV4_UDP_RECEIVE_FILTER_MACROS_SVH
`define IPV4_UDP_RECEIVE_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define IURF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define IURF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/iurf_pkg.sv =====
package iurf_pkg;

	localparam logic [16:0] IP_MIN_HDR = 17'd20;
	localparam logic [15:0] UDP_HDR    = 16'd8;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [3:0]  IP_V4      = 4'd4;

	// byte address bit 2 picks the register
	localparam logic REG_LOCAL_PORT  = 1'b0;
	localparam logic REG_REMOTE_PORT = 1'b1;

	typedef enum logic [3:0] {
		DROP_NONE      = 4'd0,
		DROP_SHORT_IP  = 4'd1,
		DROP_NOT_V4    = 4'd2,
		DROP_NOT_UDP   = 4'd3,
		DROP_SHORT_UDP = 4'd4,
		DROP_DPORT     = 4'd5,
		DROP_SPORT     = 4'd6,
		DROP_UDP_LEN   = 4'd7,
		DROP_TRUNCATED = 4'd8
	} drop_t;

	typedef struct packed {
		logic [15:0] local_port;
		logic [15:0] remote_port;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       payload_valid;
		logic       frame_end;
		logic       accepted;
		logic [3:0] drop_reason;
	} res_t;

endpackage

// ===== rtl/iurf_if.sv =====
interface iurf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       rx_last;

	modport source (output valid, output rx_byte, output rx_last, input ready);
	modport sink (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface iurf_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       payload_valid;
	logic       frame_end;
	logic       accepted;
	logic [3:0] drop_reason;

	modport source (output valid, output out_byte, output payload_valid, output frame_end,
		output accepted, output drop_reason, input ready);
	modport sink (input valid, input out_byte, input payload_valid, input frame_end,
		input accepted, input drop_reason, output ready);
endinterface

// ===== rtl/ipv4_udp_receive_filter.sv =====
// IPv4/UDP receive filter. Takes one datagram byte per clock on rx while rx is ready, and
// every accepted byte gives exactly one transaction on tx, carrying the byte, a payload
// mark (inside the UDP payload and below COPY_LIMIT bytes of it) and, on the last byte,
// the verdict: accepted, or a drop reason. Header parsing and the verdict are done in one
// pass between the rx handshake and the result register, so the sustained rate is one
// byte per clock while tx keeps up; a skid register behind the result register keeps rx
// ready for one extra transaction while tx stalls, and rx ready drops only when both are
// full. local_port and remote_port must be written over the APB port at byte addresses 0
// and 4 while no datagram is in flight; the block itself does not enforce this.
module ipv4_udp_receive_filter #(
	parameter int COPY_LIMIT = 1087
) (
	input  logic        clk,
	input  logic        arst_n,
	iurf_rx_if.sink     rx,
	iurf_tx_if.source   tx,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import iurf_pkg::*;

	localparam logic [15:0] CopyLim = 16'(COPY_LIMIT);

	cfg_t cfg;

	logic [15:0] off_q;
	logic [5:0]  hl_q;
	logic [3:0]  ver_q;
	logic [7:0]  proto_q;
	logic [15:0] dport_q;
	logic [15:0] sport_q;
	logic [15:0] ulen_q;

	logic [5:0]  hl_n;
	logic [3:0]  ver_n;
	logic [7:0]  proto_n;
	logic [15:0] dport_n;
	logic [15:0] sport_n;
	logic [15:0] ulen_n;

	logic        in_udp;
	logic [15:0] rel;
	logic [15:0] lim;
	logic        pv;
	logic [16:0] total;
	logic [16:0] hl_ext;
	drop_t       reason;
	res_t        res;
	logic        rx_fire;
	logic        tx_fire;

	res_t        out_q;
	logic        out_valid_q;
	res_t        skid_q;
	logic        skid_valid_q;

	iurf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign rx.ready = !skid_valid_q;
	assign rx_fire  = rx.valid && rx.ready;
	assign tx_fire  = out_valid_q && tx.ready;

	// header fields as they stand after this byte
	always_comb begin
		hl_n    = (off_q == 16'd0) ? {rx.rx_byte[3:0], 2'b00} : hl_q;
		ver_n   = (off_q == 16'd0) ? rx.rx_byte[7:4] : ver_q;
		proto_n = (off_q == 16'd9) ? rx.rx_byte : proto_q;
		in_udp  = off_q >= {10'd0, hl_n};
		rel     = off_q - {10'd0, hl_n};
		sport_n = sport_q;
		dport_n = dport_q;
		ulen_n  = ulen_q;
		if (in_udp) begin
			case (rel)
				16'd0:   sport_n[15:8] = rx.rx_byte;
				16'd1:   sport_n[7:0]  = rx.rx_byte;
				16'd2:   dport_n[15:8] = rx.rx_byte;
				16'd3:   dport_n[7:0]  = rx.rx_byte;
				16'd4:   ulen_n[15:8]  = rx.rx_byte;
				16'd5:   ulen_n[7:0]   = rx.rx_byte;
				default: ;
			endcase
		end
	end

	// payload mark
	always_comb begin
		lim = ulen_n - UDP_HDR;
		if (lim > CopyLim) begin
			lim = CopyLim;
		end
		pv = in_udp && (rel >= UDP_HDR) && (ulen_n >= UDP_HDR) && ((rel - UDP_HDR) < lim);
	end

	// verdict, first failing check wins
	always_comb begin
		total  = {1'b0, off_q} + 17'd1;
		hl_ext = {11'd0, hl_n};
		if (total < IP_MIN_HDR) begin
			reason = DROP_SHORT_IP;
		end else if (ver_n != IP_V4) begin
			reason = DROP_NOT_V4;
		end else if (proto_n != PROTO_UDP) begin
			reason = DROP_NOT_UDP;
		end else if (total < hl_ext + {1'b0, UDP_HDR}) begin
			reason = DROP_SHORT_UDP;
		end else if (dport_n != cfg.local_port) begin
			reason = DROP_DPORT;
		end else if (sport_n != cfg.remote_port) begin
			reason = DROP_SPORT;
		end else if (ulen_n < UDP_HDR) begin
			reason = DROP_UDP_LEN;
		end else if (total < hl_ext + {1'b0, ulen_n}) begin
			reason = DROP_TRUNCATED;
		end else begin
			reason = DROP_NONE;
		end
	end

	always_comb begin
		res.out_byte      = rx.rx_byte;
		res.payload_valid = pv;
		res.frame_end     = rx.rx_last;
		res.accepted      = rx.rx_last && (reason == DROP_NONE);
		res.drop_reason   = rx.rx_last ? reason : DROP_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			hl_q    <= '0;
			ver_q   <= '0;
			proto_q <= '0;
			dport_q <= '0;
			sport_q <= '0;
			ulen_q  <= '0;
		end else if (rx_fire) begin
			if (rx.rx_last) begin
				off_q   <= '0;
				hl_q    <= '0;
				ver_q   <= '0;
				proto_q <= '0;
				dport_q <= '0;
				sport_q <= '0;
				ulen_q  <= '0;
			end else begin
				// offset sticks at its top value on oversized datagrams
				if (off_q != 16'hFFFF) begin
					off_q <= off_q + 16'd1;
				end
				hl_q    <= hl_n;
				ver_q   <= ver_n;
				proto_q <= proto_n;
				dport_q <= dport_n;
				sport_q <= sport_n;
				ulen_q  <= ulen_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || tx_fire) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= rx_fire;
			end
		end else if (rx_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || tx_fire) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (rx_fire) begin
			skid_q <= res;
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.out_byte      = out_q.out_byte;
	assign tx.payload_valid = out_q.payload_valid;
	assign tx.frame_end     = out_q.frame_end;
	assign tx.accepted      = out_q.accepted;
	assign tx.drop_reason   = out_q.drop_reason;

endmodule

// ===== rtl/iurf_regs.sv =====
module iurf_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output iurf_pkg::cfg_t     cfg
);
	import iurf_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_LOCAL_PORT:  cfg_q.local_port  <= pwdata[15:0];
				REG_REMOTE_PORT: cfg_q.remote_port <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LOCAL_PORT:  prdata = {16'd0, cfg_q.local_port};
			REG_REMOTE_PORT: prdata = {16'd0, cfg_q.remote_port};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/iurf_checker.sv =====
`include "ipv4_udp_receive_filter_macros.svh"

module iurf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] out_byte,
	input logic       payload_valid,
	input logic       frame_end,
	input logic       accepted,
	input logic [3:0] drop_reason
);
	import iurf_pkg::*;

	// verdict fields stay quiet away from the last byte
	`IURF_ASSERT_IMP(a_quiet_mid_frame, tx_valid && !frame_end,
		!accepted && (drop_reason == DROP_NONE), "verdict shown before frame end")

	`IURF_ASSERT_IMP(a_verdict_consistent, tx_valid && frame_end,
		accepted == (drop_reason == DROP_NONE), "accepted disagrees with drop reason")

	`IURF_ASSERT_IMP(a_reason_range, tx_valid, drop_reason <= DROP_TRUNCATED,
		"drop reason out of range")

	`IURF_ASSERT_NXT(a_tx_hold, tx_valid && !tx_ready,
		tx_valid && $stable(out_byte) && $stable(payload_valid) && $stable(frame_end),
		"stalled tx transaction changed")

endmodule

bind ipv4_udp_receive_filter iurf_checker u_iurf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tx_valid      (tx.valid),
	.tx_ready      (tx.ready),
	.out_byte      (tx.out_byte),
	.payload_valid (tx.payload_valid),
	.frame_end     (tx.frame_end),
	.accepted      (tx.accepted),
	.drop_reason   (tx.drop_reason)
);
